// ===== hw/rtl/hdmi_acr_pkg.sv =====
// Shared types and constants for the HDMI audio clock regeneration N/CTS selector.
// No dependencies; imported by hdmi_acr_lookup and the top level.
`default_nettype none

package hdmi_acr_pkg;

  typedef struct packed {
    logic [17:0] audio_rate_hz;
    logic [28:0] pixel_clock_hz;
  } hdmi_acr_in_t;

  typedef struct packed {
    logic [19:0] n_value;
    logic [19:0] cts_value;
    logic        supported;
  } hdmi_acr_out_t;

  // Table lookup result handed from the lookup to the scaling logic.
  // CTS is carried as CTS / 25; every table entry is a multiple of 25.
  typedef struct packed {
    logic        rate_known;
    logic [16:0] n_base;
    logic [13:0] cts_q25;
  } hdmi_acr_lk_t;

  localparam logic [7:0] RatioReset = 8'd100;
  localparam logic [7:0] RatioDeep  = 8'd150;

  // floor(x / 1000) = (x * NDivMult) >> NDivShift for x < 2^25
  localparam logic [25:0] NDivMult  = 26'd34359739;
  localparam int          NDivShift = 35;

  localparam logic [17:0] Rate32k  = 18'd32000;
  localparam logic [17:0] Rate44k  = 18'd44100;
  localparam logic [17:0] Rate48k  = 18'd48000;
  localparam logic [17:0] Rate88k  = 18'd88200;
  localparam logic [17:0] Rate96k  = 18'd96000;
  localparam logic [17:0] Rate176k = 18'd176400;
  localparam logic [17:0] Rate192k = 18'd192000;

  localparam logic [28:0] Clk25174k = 29'd25174000;
  localparam logic [28:0] Clk25200k = 29'd25200000;
  localparam logic [28:0] Clk27000k = 29'd27000000;
  localparam logic [28:0] Clk27020k = 29'd27020000;
  localparam logic [28:0] Clk54000k = 29'd54000000;
  localparam logic [28:0] Clk74170k = 29'd74170000;
  localparam logic [28:0] Clk74250k = 29'd74250000;
  localparam logic [28:0] Clk148350k = 29'd148350000;
  localparam logic [28:0] Clk148500k = 29'd148500000;
  localparam logic [28:0] Clk297000k = 29'd297000000;

endpackage

`default_nettype wire

// ===== hw/rtl/hdmi_acr_lookup.sv =====
// Table lookup for N and unscaled CTS (held as CTS / 25) per rate family and pixel clock.
// Purely combinational; depends on hdmi_acr_pkg.
`default_nettype none

module hdmi_acr_lookup
  import hdmi_acr_pkg::*;
(
  input  hdmi_acr_in_t req,
  input  logic         deep,
  output hdmi_acr_lk_t lk
);

  function automatic logic [14:0] n_fam32(input logic [28:0] clk_hz, input logic dc);
    logic [14:0] n;
    n = 15'd4096;
    unique case (clk_hz)
      Clk25174k:  n = dc ? 15'd9152 : 15'd4576;
      Clk27020k:  n = dc ? 15'd8192 : 15'd4096;
      Clk74170k:  n = 15'd11648;
      Clk148350k: n = 15'd11648;
      Clk297000k: n = dc ? 15'd6144 : 15'd3072;
      default:    n = 15'd4096;
    endcase
    return n;
  endfunction

  function automatic logic [14:0] n_fam44(input logic [28:0] clk_hz, input logic dc);
    logic [14:0] n;
    n = 15'd6272;
    unique case (clk_hz)
      Clk25174k:  n = 15'd7007;
      Clk74170k:  n = 15'd17836;
      Clk148350k: n = dc ? 15'd17836 : 15'd8918;
      Clk297000k: n = dc ? 15'd9408 : 15'd4704;
      default:    n = 15'd6272;
    endcase
    return n;
  endfunction

  function automatic logic [14:0] n_fam48(input logic [28:0] clk_hz, input logic dc);
    logic [14:0] n;
    n = 15'd6144;
    unique case (clk_hz)
      Clk25174k:  n = dc ? 15'd9152 : 15'd6864;
      Clk27020k:  n = dc ? 15'd8192 : 15'd6144;
      Clk74170k:  n = 15'd11648;
      Clk148350k: n = dc ? 15'd11648 : 15'd5824;
      Clk297000k: n = dc ? 15'd10240 : 15'd5120;
      default:    n = 15'd6144;
    endcase
    return n;
  endfunction

  // Entries are CTS / 25
  function automatic logic [13:0] cts_row48(input logic [28:0] clk_hz);
    logic [13:0] c;
    c = '0;
    unique case (clk_hz)
      Clk25200k:  c = 14'd1008;
      Clk27000k:  c = 14'd1080;
      Clk54000k:  c = 14'd2160;
      Clk74250k:  c = 14'd2970;
      Clk148500k: c = 14'd5940;
      Clk297000k: c = 14'd9900;
      Clk25174k:  c = 14'd1125;
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [13:0] cts_row44(input logic [28:0] clk_hz);
    logic [13:0] c;
    c = '0;
    unique case (clk_hz)
      Clk25200k:  c = 14'd1120;
      Clk25174k:  c = 14'd1250;
      Clk27000k:  c = 14'd1200;
      Clk54000k:  c = 14'd2400;
      Clk74250k:  c = 14'd3300;
      Clk148500k: c = 14'd6600;
      Clk297000k: c = 14'd9900;
      default:    c = '0;
    endcase
    return c;
  endfunction

  logic [28:0] clk_hz;

  assign clk_hz = req.pixel_clock_hz;

  always_comb begin
    lk = '0;
    unique case (req.audio_rate_hz)
      Rate32k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {2'b00, n_fam32(clk_hz, deep)};
        // 32 kHz borrows the 48 kHz CTS row except at 297 MHz
        if (clk_hz == Clk297000k) begin
          lk.cts_q25 = 14'd8910;
        end else begin
          lk.cts_q25 = cts_row48(clk_hz);
        end
      end
      Rate44k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {2'b00, n_fam44(clk_hz, deep)};
        lk.cts_q25    = cts_row44(clk_hz);
      end
      Rate88k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {1'b0, n_fam44(clk_hz, deep), 1'b0};
        lk.cts_q25    = cts_row44(clk_hz);
      end
      Rate176k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {n_fam44(clk_hz, deep), 2'b00};
        lk.cts_q25    = cts_row44(clk_hz);
      end
      Rate48k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {2'b00, n_fam48(clk_hz, deep)};
        lk.cts_q25    = cts_row48(clk_hz);
      end
      Rate96k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {1'b0, n_fam48(clk_hz, deep), 1'b0};
        lk.cts_q25    = cts_row48(clk_hz);
      end
      Rate192k: begin
        lk.rate_known = 1'b1;
        lk.n_base     = {n_fam48(clk_hz, deep), 2'b00};
        lk.cts_q25    = cts_row48(clk_hz);
      end
      default: begin
        lk = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hdmi_audio_n_cts_select_top.sv =====
// HDMI audio clock regeneration N/CTS selector, top level.
// Depends on hdmi_acr_pkg and hdmi_acr_lookup.
//
// Usage:
//   A request (sample rate and pixel clock, both in Hz) is taken at each rising
//   edge where start is high and busy is low. busy is always low, so a new
//   request may be presented every cycle.
//   cfg_we / cfg_wdata write the TMDS ratio register (percent, 100 after reset).
//   Write it only while no request is in flight.
//   Each request yields one result: done is high for one cycle with result
//   holding N, scaled CTS and the supported flag.
// Timing:
//   Input register, then table lookup and ratio scaling in one short pass,
//   then the output register. done comes from the input register's valid flag
//   through the output register; throughput is one request per cycle.
//   The pass holds one 14x8 multiply for CTS and, in parallel, the reciprocal
//   multiply for the fallback N.
// Reset:
//   rst clears both valid flags and sets the ratio to 100; in-flight requests
//   are dropped. The receiver cannot stall; results are never held back.
`default_nettype none

module hdmi_audio_n_cts_select_top
  import hdmi_acr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hdmi_acr_in_t  request,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  output logic          done,
  output hdmi_acr_out_t result
);

  logic [7:0]   tmds_ratio;
  logic         deep;

  logic         v0;
  hdmi_acr_in_t req0;

  hdmi_acr_lk_t lk;
  logic [50:0]  nprod;
  logic [21:0]  ctsprod;
  logic [19:0]  n_next;
  logic [19:0]  cts_next;

  assign busy = 1'b0;
  assign deep = (tmds_ratio == RatioDeep);

  always_ff @(posedge clk) begin
    if (rst) begin
      tmds_ratio <= RatioReset;
    end else if (cfg_we) begin
      tmds_ratio <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req0 <= request;
    end
  end

  hdmi_acr_lookup u_lookup (
    .req  (req0),
    .deep (deep),
    .lk   (lk)
  );

  // Fallback N = 128 * rate / 1000 runs alongside the lookup
  assign nprod  = {26'd0, req0.audio_rate_hz, 7'b0} * {25'd0, NDivMult};
  assign n_next = lk.rate_known ? {3'b000, lk.n_base}
                                : {4'b0000, nprod[NDivShift +: 16]};

  // CTS = 25 * q, so CTS * ratio / 100 = q * ratio / 4
  assign ctsprod  = {8'd0, lk.cts_q25} * {14'd0, tmds_ratio};
  assign cts_next = ctsprod[21:2];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v0;
    end
  end

  always_ff @(posedge clk) begin
    result.n_value   <= n_next;
    result.cts_value <= cts_next;
    result.supported <= (cts_next != '0);
  end

  a_supported_matches_cts : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.supported == (result.cts_value != 20'd0)))
    else $error("supported flag disagrees with CTS");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing two cycles after request");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v0))
    else $error("result without a request");

  a_n_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.n_value <= 20'd71344))
    else $error("N out of range");

endmodule

`default_nettype wire

// ===== tb/sv/hdmi_audio_n_cts_select_top_tb.sv =====
// Self-checking testbench for hdmi_audio_n_cts_select_top: directed and random rate/clock
// requests under several TMDS ratios, results checked against an in-bench N/CTS predictor.
// Depends on hdmi_acr_pkg and the RTL top level.
`timescale 1ns / 1ps

module hdmi_audio_n_cts_select_top_tb
  import hdmi_acr_pkg::*;
();

  typedef enum logic [1:0] {OpItem, OpWrite, OpDrain} op_kind_t;
  typedef enum logic [1:0] {FamNone, Fam32, Fam44, Fam48} rate_family_t;

  typedef struct packed {
    op_kind_t     kind;
    logic [3:0]   gap;
    logic [7:0]   wdata;
    hdmi_acr_in_t req;
  } pending_op_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  hdmi_acr_in_t  request = '0;
  logic          cfg_we = 1'b0;
  logic [7:0]    cfg_wdata = '0;
  logic          done;
  hdmi_acr_out_t result;

  pending_op_t   op_queue[$];
  hdmi_acr_out_t acr_expected[$];
  logic [7:0]    tmds_pct = RatioReset;
  logic          took_item = 1'b0;
  int            quiet_cycles = 0;
  int            gap_left = 0;
  int            mismatches = 0;

  hdmi_audio_n_cts_select_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .result   (result)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // N and scaled CTS for one request at the given ratio
  function automatic hdmi_acr_out_t acr_expect(hdmi_acr_in_t rq, logic [7:0] pct);
    rate_family_t  fam;
    int unsigned   scale;
    int unsigned   n;
    int unsigned   cts;
    logic [28:0]   ck;
    bit            deep;
    hdmi_acr_out_t res;
    ck = rq.pixel_clock_hz;
    deep = (pct == RatioDeep);
    fam = FamNone;
    scale = 1;
    n = 0;
    cts = 0;
    case (rq.audio_rate_hz)
      Rate32k:  fam = Fam32;
      Rate44k:  fam = Fam44;
      Rate88k: begin
        fam = Fam44;
        scale = 2;
      end
      Rate176k: begin
        fam = Fam44;
        scale = 4;
      end
      Rate48k:  fam = Fam48;
      Rate96k: begin
        fam = Fam48;
        scale = 2;
      end
      Rate192k: begin
        fam = Fam48;
        scale = 4;
      end
      default:  fam = FamNone;
    endcase
    case (fam)
      Fam32: begin
        if (ck == Clk25174k) n = deep ? 9152 : 4576;
        else if (ck == Clk27020k) n = deep ? 8192 : 4096;
        else if (ck == Clk74170k || ck == Clk148350k) n = 11648;
        else if (ck == Clk297000k) n = deep ? 6144 : 3072;
        else n = 4096;
      end
      Fam44: begin
        if (ck == Clk25174k) n = 7007;
        else if (ck == Clk74170k) n = 17836;
        else if (ck == Clk148350k) n = deep ? 17836 : 8918;
        else if (ck == Clk297000k) n = deep ? 9408 : 4704;
        else n = 6272;
      end
      Fam48: begin
        if (ck == Clk25174k) n = deep ? 9152 : 6864;
        else if (ck == Clk27020k) n = deep ? 8192 : 6144;
        else if (ck == Clk74170k) n = 11648;
        else if (ck == Clk148350k) n = deep ? 11648 : 5824;
        else if (ck == Clk297000k) n = deep ? 10240 : 5120;
        else n = 6144;
      end
      default: n = 0;
    endcase
    if (fam == FamNone) n = (128 * int'(rq.audio_rate_hz)) / 1000;
    else n = n * scale;
    case (fam)
      Fam44: begin
        case (ck)
          Clk25200k:  cts = 28000;
          Clk25174k:  cts = 31250;
          Clk27000k:  cts = 30000;
          Clk54000k:  cts = 60000;
          Clk74250k:  cts = 82500;
          Clk148500k: cts = 165000;
          Clk297000k: cts = 247500;
          default:    cts = 0;
        endcase
      end
      Fam32, Fam48: begin
        // 32 kHz has its own entry at 297 MHz, otherwise it borrows the 48 kHz row
        if (fam == Fam32 && ck == Clk297000k) cts = 222750;
        else begin
          case (ck)
            Clk25200k, Clk27000k, Clk54000k, Clk74250k, Clk148500k: cts = ck / 1000;
            Clk297000k: cts = 247500;
            Clk25174k:  cts = 28125;
            default:    cts = 0;
          endcase
        end
      end
      default: cts = 0;
    endcase
    cts = (cts * pct) / 100;
    res.n_value = n[19:0];
    res.cts_value = cts[19:0];
    res.supported = (cts != 0);
    return res;
  endfunction

  function automatic logic [17:0] rate_at(int idx);
    case (idx)
      0:       return Rate32k;
      1:       return Rate44k;
      2:       return Rate48k;
      3:       return Rate88k;
      4:       return Rate96k;
      5:       return Rate176k;
      default: return Rate192k;
    endcase
  endfunction

  function automatic logic [28:0] clk_at(int idx);
    case (idx)
      0:       return Clk25174k;
      1:       return Clk25200k;
      2:       return Clk27000k;
      3:       return Clk27020k;
      4:       return Clk54000k;
      5:       return Clk74170k;
      6:       return Clk74250k;
      7:       return Clk148350k;
      8:       return Clk148500k;
      default: return Clk297000k;
    endcase
  endfunction

  function automatic void queue_request(logic [17:0] rate, logic [28:0] pclk, int gap);
    pending_op_t op;
    op.kind = OpItem;
    op.gap = gap[3:0];
    op.wdata = '0;
    op.req.audio_rate_hz = rate;
    op.req.pixel_clock_hz = pclk;
    op_queue.push_back(op);
  endfunction

  function automatic void queue_op(op_kind_t kind, logic [7:0] wdata);
    pending_op_t op;
    op.kind = kind;
    op.gap = '0;
    op.wdata = wdata;
    op.req = '0;
    op_queue.push_back(op);
  endfunction

  // Mostly table rates and clocks, with near misses and full-range noise mixed in
  task automatic queue_random_phase(int count, bit idle_ok);
    logic [17:0] rate;
    logic [28:0] pclk;
    int          pick;
    int          gap;
    bit          calm;
    calm = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 6) rate = rate_at($urandom_range(0, 6));
      else if (pick == 7)
        rate = rate_at($urandom_range(0, 6)) + ($urandom_range(0, 1) ? 18'd1 : -18'd1);
      else rate = 18'($urandom_range(0, 262143));
      pick = $urandom_range(0, 9);
      if (pick <= 5) pclk = clk_at($urandom_range(0, 9));
      else if (pick == 6)
        pclk = clk_at($urandom_range(0, 9)) + ($urandom_range(0, 1) ? 29'd1 : -29'd1);
      else if (pick == 7) pclk = $urandom_range(0, 1) ? 29'd340000000 : 29'd0;
      else pclk = 29'($urandom_range(0, 340000000));
      gap = 0;
      if (idle_ok && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      queue_request(rate, pclk, gap);
    end
  endtask

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Present queued requests and register writes at the falling edge, holding drains until no result is pending
  always @(negedge clk) begin : feed
    pending_op_t  op;
    logic         nxt_start;
    logic         nxt_we;
    logic [7:0]   nxt_wdata;
    hdmi_acr_in_t nxt_req;
    nxt_start = start && !took_item;
    nxt_we = 1'b0;
    nxt_wdata = cfg_wdata;
    nxt_req = request;
    if (!rst && !nxt_start) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (op_queue.size() != 0) begin
        op = op_queue[0];
        case (op.kind)
          OpItem: begin
            op = op_queue.pop_front();
            nxt_start = 1'b1;
            nxt_req = op.req;
            gap_left = op.gap;
          end
          OpWrite: begin
            // write the ratio only with the pipeline empty
            if (acr_expected.size() == 0 && quiet_cycles >= 3) begin
              op = op_queue.pop_front();
              nxt_we = 1'b1;
              nxt_wdata = op.wdata;
              tmds_pct = op.wdata;
            end
          end
          default: begin
            if (acr_expected.size() == 0) op = op_queue.pop_front();
          end
        endcase
      end
    end
    start <= nxt_start;
    request <= nxt_req;
    cfg_we <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  // Record each accepted transaction and check each result against the oldest expectation
  always @(posedge clk) begin : watch
    hdmi_acr_out_t want;
    if (rst) begin
      took_item <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (acr_expected.size() == 0) begin
          note_mismatch("result with nothing pending, n_value", result.n_value, 0);
        end else begin
          want = acr_expected.pop_front();
          if (result.n_value !== want.n_value)
            note_mismatch("n_value", result.n_value, want.n_value);
          if (result.cts_value !== want.cts_value)
            note_mismatch("cts_value", result.cts_value, want.cts_value);
          if (result.supported !== want.supported)
            note_mismatch("supported", result.supported, want.supported);
        end
      end
      took_item <= start && !busy;
      if (start && !busy) acr_expected.push_back(acr_expect(request, tmds_pct));
      quiet_cycles <= (start || acr_expected.size() != 0) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] ratio_plan[8];
    ratio_plan = '{RatioDeep, 8'd0, 8'd255, 8'd1, RatioReset, 8'd0, RatioDeep, 8'd99};
    ratio_plan[5] = 8'($urandom_range(0, 255));

    // field extremes and the special cases, at the reset ratio
    queue_request(18'd0, 29'd0, 0);
    queue_request(18'd262143, 29'd340000000, 0);
    queue_request(18'h2AAAA, 29'h15555555, 0);
    queue_request(Rate32k, Clk297000k, 0);
    queue_request(Rate32k, Clk25174k, 0);
    queue_request(Rate32k, Clk54000k, 0);
    queue_request(Rate32k, Clk27020k, 0);
    queue_request(Rate32k, Clk74170k, 0);
    queue_request(Rate32k, 29'd1, 2);
    queue_request(Rate44k, Clk25174k, 0);
    queue_request(Rate44k, Clk148500k, 0);
    queue_request(Rate44k, Clk27020k, 0);
    queue_request(Rate44k, Clk74170k, 0);
    queue_request(Rate48k, Clk25200k, 0);
    queue_request(Rate48k, Clk148350k, 0);
    queue_request(Rate48k, Clk297000k, 0);
    queue_request(Rate48k, 29'd12345678, 5);
    queue_request(Rate88k, Clk297000k, 0);
    queue_request(Rate96k, Clk74250k, 0);
    queue_request(Rate176k, Clk148350k, 0);
    queue_request(Rate192k, Clk27000k, 0);
    queue_request(Rate192k, Clk297000k, 0);
    queue_request(18'd31999, Clk25200k, 0);
    queue_request(18'd44101, Clk27000k, 0);

    queue_random_phase(70, 1'b1);
    queue_op(OpDrain, '0);
    queue_random_phase(70, 1'b1);
    foreach (ratio_plan[p]) begin
      queue_op(OpWrite, ratio_plan[p]);
      queue_random_phase(142, p != 7);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || start || acr_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
